FILE: hdl/rgb_byte_histogram_macros.svh
// Assertion macros shared by the histogram checker.
`ifndef RGB_BYTE_HISTOGRAM_MACROS_SVH
`define RGB_BYTE_HISTOGRAM_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RGBH_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgbh check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RGBH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgbh check failed");

`endif

FILE: hdl/rgbh_pkg.sv
// Package with the constants, codes and shared types of the RGB byte histogram.
`timescale 1ns / 1ps

package rgbh_pkg;

   localparam int OFFSET_FIELD_POS = 10;
   localparam int NUM_BINS         = 256;
   localparam int COUNT_WIDTH      = 32;
   localparam int NUM_CHANNELS     = 3;

   localparam int REQ_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int CHAN_W  = 2;
   localparam int BIN_W   = $clog2(NUM_BINS);
   localparam int OUT_W   = 32;
   localparam int POS_W   = 32;
   localparam int DEPTH   = NUM_CHANNELS * NUM_BINS;
   localparam int ADDR_W  = CHAN_W + BIN_W;
   localparam int PHASE_W = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_DATA  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   localparam logic [CHAN_W-1:0] CHAN_RED    = 2'd0;
   localparam logic [CHAN_W-1:0] CHAN_GREEN  = 2'd1;
   localparam logic [CHAN_W-1:0] CHAN_BLUE   = 2'd2;
   localparam logic [CHAN_W-1:0] CHAN_UNUSED = 2'd3;

   localparam logic [PHASE_W-1:0] PHASE_BLUE  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_GREEN = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_RED   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_BYTE  = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic take_read;
      logic take_clear;
      logic sweep;
      logic write_back;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_busy;
      logic sweep_last;
   } dp_status_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] value);
      return (&value) ? value : value + COUNT_WIDTH'(1);
   endfunction

endpackage

FILE: hdl/rgbh_req_if.sv
// Request channel interface of the RGB byte histogram.
`timescale 1ns / 1ps

interface rgbh_req_if import rgbh_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [BYTE_W-1:0]   data_byte;
   logic [CHAN_W-1:0]   read_channel;
   logic [BIN_W-1:0]    read_bin;

   modport source (output valid, req_type, data_byte, read_channel, read_bin, input ready);
   modport sink   (input valid, req_type, data_byte, read_channel, read_bin, output ready);
endinterface

FILE: hdl/rgbh_rsp_if.sv
// Response channel interface of the RGB byte histogram.
`timescale 1ns / 1ps

interface rgbh_rsp_if import rgbh_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] bin_count;

   modport source (output valid, bin_count, input ready);
   modport sink   (input valid, bin_count, output ready);
endinterface

FILE: hdl/rgb_byte_histogram.sv
// Top level of the RGB byte histogram over a streamed bitmap file.
//
//   Channel   Direction  Handshake            Payload
//   req_bus   in         valid / ready        req_type, data_byte, read_channel, read_bin
//   rsp_bus   out        valid / ready        bin_count
//
// For a data byte or a counter read, the request is accepted and the counter RAM is read,
// then its registered read data is either incremented and written back or loaded into
// the response register. This sequence follows from the registered single RAM read port.
// A clear transaction is accepted and then runs a sweep that writes zero into every
// counter; the same sweep runs after reset, with no request accepted.
// A pending response does not block data bytes or clears; only a read waits until the
// response register is free or being taken in the same cycle.
`timescale 1ns / 1ps

module rgb_byte_histogram import rgbh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rgbh_req_if.sink  req_bus,
   rgbh_rsp_if.source rsp_bus
);

   // Commands flow from the controller to the datapath; status flows back.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller owns the request handshake and sequences clear, update and read.
   rgbh_ctrl u_rgbh_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath tracks the byte position, the captured data start and the channel
   // phase, holds the 768 saturating counters in RAM and drives the response channel.
   rgbh_dp u_rgbh_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .data_byte    (req_bus.data_byte),
      .read_channel (req_bus.read_channel),
      .read_bin     (req_bus.read_bin),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .bin_count    (rsp_bus.bin_count)
   );

endmodule

FILE: hdl/rgbh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rgbh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rgbh_ctrl.sv
// Controller state machine of the RGB byte histogram.
`timescale 1ns / 1ps

module rgbh_ctrl import rgbh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [REQ_W-1:0] req_type,
   output logic             req_ready,
   input  dp_status_type    status,
   output dp_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // A read needs the response register free by the time its data returns.
            req_ready = (req_kind_type'(req_type) != REQ_READ) || !status.rsp_busy;
            if (req_valid && req_ready) begin
               unique case (req_kind_type'(req_type))
                  REQ_DATA: begin
                     cmd.take_byte = 1'b1;
                     state_in      = ST_BYTE;
                  end
                  REQ_READ: begin
                     cmd.take_read = 1'b1;
                     state_in      = ST_READ;
                  end
                  REQ_CLEAR: begin
                     cmd.take_clear = 1'b1;
                     state_in       = ST_CLEAR;
                  end
                  REQ_NONE: begin
                     state_in = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BYTE: begin
            cmd.write_back = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_READ: begin
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/rgbh_dp.sv
// Datapath of the RGB byte histogram: position tracking, counter RAM and response register.
`timescale 1ns / 1ps

module rgbh_dp import rgbh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_status_type     status,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [CHAN_W-1:0] read_channel,
   input  logic [BIN_W-1:0]  read_bin,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [OUT_W-1:0]  bin_count
);

   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [BYTE_W-1:0]      start_ff, start_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [ADDR_W-1:0]      sweep_ff, sweep_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   upd_ff, upd_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   unused_ff, unused_in;
   logic [OUT_W-1:0]       rsp_data_ff, rsp_data_in;

   logic                   pos_full;
   logic                   capture;
   logic [BYTE_W-1:0]      start_now;
   logic [POS_W-1:0]       start_eff;
   logic                   count_now;
   logic [CHAN_W-1:0]      byte_chan;
   logic [ADDR_W-1:0]      byte_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;

   // Effective start of pixel data, including a capture in this very byte.
   always_comb begin
      pos_full  = &pos_ff;
      capture   = (pos_ff == POS_W'(OFFSET_FIELD_POS));
      start_now = capture ? data_byte : start_ff;
      if (start_now <= BYTE_W'(OFFSET_FIELD_POS)) begin
         start_eff = POS_W'(OFFSET_FIELD_POS + 1);
      end else begin
         start_eff = POS_W'(start_now);
      end
      count_now = !pos_full && (pos_ff >= start_eff);
      case (phase_ff)
         PHASE_BLUE:  byte_chan = CHAN_BLUE;
         PHASE_GREEN: byte_chan = CHAN_GREEN;
         default:     byte_chan = CHAN_RED;
      endcase
      byte_addr = {byte_chan, data_byte};
      rd_addr   = cmd.take_byte ? byte_addr : {read_channel, read_bin};
   end

   always_comb begin
      pos_in       = pos_ff;
      start_in     = start_ff;
      phase_in     = phase_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      upd_in       = upd_ff;
      addr_in      = addr_ff;
      unused_in    = unused_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.take_byte) begin
         upd_in  = count_now;
         addr_in = byte_addr;
         if (!pos_full) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (capture) begin
            start_in = data_byte;
         end
         if (count_now) begin
            phase_in = (phase_ff == PHASE_RED) ? PHASE_BLUE : phase_ff + PHASE_W'(1);
         end
      end
      if (cmd.take_read) begin
         unused_in = (read_channel == CHAN_UNUSED);
      end
      if (cmd.take_clear) begin
         pos_in   = '0;
         start_in = '0;
         phase_in = PHASE_BLUE;
         sweep_in = '0;
      end
      if (cmd.sweep) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = unused_ff ? '0 : OUT_W'(rd_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         start_ff     <= '0;
         phase_ff     <= PHASE_BLUE;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         phase_ff     <= phase_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_ff      <= upd_in;
      addr_ff     <= addr_in;
      unused_ff   <= unused_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The clearing sweep and the saturating write-back share the single write port.
   always_comb begin
      wr_en   = cmd.sweep || (cmd.write_back && upd_ff);
      wr_addr = cmd.sweep ? sweep_ff : addr_ff;
      wr_data = cmd.sweep ? '0 : sat_inc(rd_data);
   end

   rgbh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_rgbh_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign status.sweep_last = (sweep_ff == ADDR_W'(DEPTH - 1));
   assign rsp_valid         = rsp_valid_ff;
   assign bin_count         = rsp_data_ff;

endmodule

FILE: hdl/rgbh_checker.sv
// Port-level checker of the RGB byte histogram and its bind statement.
`timescale 1ns / 1ps
`include "rgb_byte_histogram_macros.svh"

module rgbh_checker import rgbh_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [REQ_W-1:0] req_type,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] bin_count
);

   logic req_fire;
   logic is_read;

   assign req_fire = req_valid && req_ready;
   assign is_read  = (req_type == REQ_READ);

   `RGBH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `RGBH_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(bin_count))
   `RGBH_ASSERT_NEXT(a_no_rsp_without_read, req_fire && !is_read && !rsp_valid, !rsp_valid)
   `RGBH_ASSERT_NOW(a_read_answers, req_fire && is_read && !rsp_valid, ##2 rsp_valid)
   `RGBH_ASSERT_NOW(a_sweep_after_reset, $past(reset), !req_ready)

endmodule

bind rgb_byte_histogram rgbh_checker u_rgbh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_type  (req_bus.req_type),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .bin_count (rsp_bus.bin_count)
);
